// ===== design/assert_macros.svh =====
// Assertion macros used by the decimal square root top level.
// Depends on nothing; included by the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds: consequent holds in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds: consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dsqrt_pkg.sv =====
// Package for the decimal square root: constants, control types, state encoding.
// No dependencies.
`timescale 1ns / 1ps

package dsqrt_pkg;

    localparam int INPUT_BITS_DEF = 31;
    localparam int ROOT_BITS      = 26;
    localparam int DIGIT_BITS     = 2;
    localparam logic [DIGIT_BITS-1:0] DIGITS_RESET = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
    } dsqrt_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROOT,
        ST_DONE
    } dsqrt_state_t;

endpackage

// ===== design/dsqrt_scale.sv =====
// Radicand scaler: multiplies the held radicand by one hundred per step (shift-add).
// Depends on dsqrt_pkg.
`timescale 1ns / 1ps

module dsqrt_scale #(
    parameter int INPUT_BITS = dsqrt_pkg::INPUT_BITS_DEF
) (
    input  logic                      clk,
    input  dsqrt_pkg::dsqrt_ctrl_t    ctrl,
    input  logic [INPUT_BITS-1:0]     radicand,
    output logic [2*((INPUT_BITS+21)/2)-1:0] value
);
    import dsqrt_pkg::*;

    localparam int ITER        = (INPUT_BITS + 21) / 2;
    localparam int SCALED_BITS = 2 * ITER;

    logic [SCALED_BITS-1:0] value_reg;
    logic [SCALED_BITS-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = SCALED_BITS'(radicand);
        end
        else if (ctrl.step)
        begin
            value_next = (value_reg << 6) + (value_reg << 5) + (value_reg << 2);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== design/dsqrt_core.sv =====
// Restoring square root core: two radicand bits in, one root bit out per step.
// Depends on dsqrt_pkg.
`timescale 1ns / 1ps

module dsqrt_core #(
    parameter int INPUT_BITS = dsqrt_pkg::INPUT_BITS_DEF
) (
    input  logic                                clk,
    input  dsqrt_pkg::dsqrt_ctrl_t              ctrl,
    input  logic [2*((INPUT_BITS+21)/2)-1:0]    scaled,
    output logic [(INPUT_BITS+21)/2-1:0]        root,
    output logic                                exact
);
    import dsqrt_pkg::*;

    localparam int ITER        = (INPUT_BITS + 21) / 2;
    localparam int SCALED_BITS = 2 * ITER;
    localparam int REM_BITS    = ITER + 3;

    logic [SCALED_BITS-1:0] rad_reg;
    logic [SCALED_BITS-1:0] rad_next;
    logic [REM_BITS-1:0]    rem_reg;
    logic [REM_BITS-1:0]    rem_next;
    logic [ITER-1:0]        root_reg;
    logic [ITER-1:0]        root_next;
    logic [REM_BITS-1:0]    shifted;
    logic [REM_BITS-1:0]    trial;
    logic [REM_BITS-1:0]    diff;
    logic                   fits;

    assign shifted = {rem_reg[REM_BITS-3:0], rad_reg[SCALED_BITS-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign diff    = shifted - trial;
    assign fits    = shifted >= trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctrl.load)
        begin
            rad_next  = scaled;
            rem_next  = '0;
            root_next = '0;
        end
        else if (ctrl.step)
        begin
            rad_next  = {rad_reg[SCALED_BITS-3:0], 2'b00};
            rem_next  = fits ? diff : shifted;
            root_next = {root_reg[ITER-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root  = root_reg;
    assign exact = (rem_reg == '0);

endmodule

// ===== design/decimal_square_root.sv =====
// Decimal square root top level: sequencer, digits register, scaler and root core.
// Depends on dsqrt_pkg, dsqrt_scale, dsqrt_core and assert_macros.svh.
//
// Usage:
//   Raise start with radicand while busy is low; the transfer happens at that edge.
//   busy stays high until the result has been presented.
//   The result appears on root_scaled and exact_square for one cycle with done high;
//   root_scaled = floor(sqrt(radicand * 100^d)), d = decimal_digits register,
//   exact_square = 1 when radicand is a perfect square (zero included).
//   The receiver cannot stall: done is a single-cycle strobe and must be taken then.
//   Sequence: after the accepting edge the scaler multiplies by one hundred once
//   per decimal digit (d), then the root core yields one root bit per cycle, with
//   ITER = (INPUT_BITS + 21) / 2 root bits (26 for 31 bits), and then done rises.
//   No new radicand is taken until the block has returned to idle after done.
//   Configuration: cfg_write with cfg_data writes the digit count (0 to 3);
//   write only while busy is low. The value is sampled when an item is accepted.
//   Reset: rst_n low returns to idle with the digit count at 3; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module decimal_square_root #(
    parameter int INPUT_BITS = dsqrt_pkg::INPUT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [INPUT_BITS-1:0]                radicand,
    output logic                                 busy,
    output logic                                 done,
    output logic [dsqrt_pkg::ROOT_BITS-1:0]      root_scaled,
    output logic                                 exact_square,
    input  logic                                 cfg_write,
    input  logic [dsqrt_pkg::DIGIT_BITS-1:0]     cfg_data
);
    import dsqrt_pkg::*;

    localparam int ITER        = (INPUT_BITS + 21) / 2;
    localparam int SCALED_BITS = 2 * ITER;
    localparam int CNT_BITS    = $clog2(ITER);

    dsqrt_state_t            state_reg;
    dsqrt_state_t            state_next;
    logic [DIGIT_BITS-1:0]   digits_reg;
    logic [DIGIT_BITS-1:0]   digits_next;
    logic [DIGIT_BITS-1:0]   pending_reg;
    logic [DIGIT_BITS-1:0]   pending_next;
    logic [CNT_BITS-1:0]     iter_reg;
    logic [CNT_BITS-1:0]     iter_next;
    dsqrt_ctrl_t             scale_ctrl;
    dsqrt_ctrl_t             core_ctrl;
    logic [SCALED_BITS-1:0]  scaled;
    logic [ITER-1:0]         root;
    logic                    exact;
    logic                    accept;

    assign accept = start && !busy;

    // Next state and counters
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        iter_next    = iter_reg;
        digits_next  = cfg_write ? cfg_data : digits_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next   = ST_SCALE;
                    pending_next = digits_reg;
                end
            end
            ST_SCALE:
            begin
                if (pending_reg == '0)
                begin
                    state_next = ST_ROOT;
                    iter_next  = CNT_BITS'(ITER - 1);
                end
                else
                begin
                    pending_next = pending_reg - 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        scale_ctrl = '0;
        core_ctrl  = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy            = 1'b0;
                scale_ctrl.load = start;
            end
            ST_SCALE:
            begin
                scale_ctrl.step = (pending_reg != '0);
                core_ctrl.load  = (pending_reg == '0);
            end
            ST_ROOT:
            begin
                core_ctrl.step = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            digits_reg  <= DIGITS_RESET;
            pending_reg <= '0;
            iter_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            digits_reg  <= digits_next;
            pending_reg <= pending_next;
            iter_reg    <= iter_next;
        end
    end

    dsqrt_scale #(
        .INPUT_BITS (INPUT_BITS)
    ) u_scale (
        .clk      (clk),
        .ctrl     (scale_ctrl),
        .radicand (radicand),
        .value    (scaled)
    );

    dsqrt_core #(
        .INPUT_BITS (INPUT_BITS)
    ) u_core (
        .clk    (clk),
        .ctrl   (core_ctrl),
        .scaled (scaled),
        .root   (root),
        .exact  (exact)
    );

    assign root_scaled  = ROOT_BITS'(root);
    assign exact_square = exact;

    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "done strobe longer than one cycle")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !done, "transfer did not start work")
    `ASSERT_SAME(a_done_after_root, clk, rst_n, done, $past(state_reg == ST_ROOT) && $past(iter_reg == '0), "result without finished root")
    `ASSERT_SAME(a_core_exclusive, clk, rst_n, core_ctrl.load || core_ctrl.step, !scale_ctrl.load && !scale_ctrl.step, "scaler and core active together")

endmodule

// ===== test/decimal_square_root_test.sv =====
// Testbench for decimal_square_root: directed and random radicands under several digit counts.
// Predicts each root by an exact integer search and checks every done strobe against it.
// Depends on dsqrt_pkg and the decimal_square_root design files.
`timescale 1ns / 1ps

module decimal_square_root_test;

    import dsqrt_pkg::*;

    localparam int RADICAND_BITS  = INPUT_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [RADICAND_BITS-1:0] RADICAND_MAX = {RADICAND_BITS{1'b1}};

    typedef struct packed {
        logic [ROOT_BITS-1:0] root;
        logic                 exact;
    } root_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [RADICAND_BITS-1:0] radicand;
    logic                     busy;
    logic                     done;
    logic [ROOT_BITS-1:0]     root_scaled;
    logic                     exact_square;
    logic                     cfg_write;
    logic [DIGIT_BITS-1:0]    cfg_data;

    root_result_t          pending_roots[$];
    logic [DIGIT_BITS-1:0] digits_now;
    int                    idle_percent;
    int                    fail_count;

    decimal_square_root #(
        .INPUT_BITS(RADICAND_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .radicand     (radicand),
        .busy         (busy),
        .done         (done),
        .root_scaled  (root_scaled),
        .exact_square (exact_square),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] floor_root(input logic [63:0] target);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int b = ROOT_BITS - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= target)
                root = trial;
        end
        return root;
    endfunction

    function automatic root_result_t predict_root(input logic [RADICAND_BITS-1:0] value,
                                                  input logic [DIGIT_BITS-1:0] digits);
        root_result_t result;
        logic [63:0]  scaled;
        logic [63:0]  whole;
        scaled = 64'(value);
        for (int i = 0; i < int'(digits); i++)
            scaled = scaled * 64'd100;
        whole        = floor_root(64'(value));
        result.exact = (whole * whole == 64'(value));
        result.root  = ROOT_BITS'(floor_root(scaled));
        return result;
    endfunction

    function automatic logic [RADICAND_BITS-1:0] pick_radicand();
        logic [63:0] k;
        logic [63:0] value;
        k = 64'($urandom_range(0, 46340));
        case ($urandom_range(0, 5))
            0: value = 64'($urandom());
            1: value = 64'($urandom_range(0, 200));
            2: value = k * k;
            3: value = (k == 0) ? 64'd1 : k * k + 64'd1 - 64'(2 * $urandom_range(0, 1));
            4: value = 64'(RADICAND_MAX) - 64'($urandom_range(0, 1000));
            default: value = 64'($urandom() >> $urandom_range(0, 31));
        endcase
        return value[RADICAND_BITS-1:0];
    endfunction

    task automatic send_radicand(input logic [RADICAND_BITS-1:0] value);
        int gap;
        gap = 0;
        if (idle_percent != 0 && $urandom_range(99) < idle_percent)
            gap = $urandom_range(1, 40);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        radicand <= value;
        do
            @(posedge clk);
        while (busy);
        pending_roots.push_back(predict_root(value, digits_now));
    endtask

    task automatic wait_until_quiet();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_roots.size() != 0 || busy);
    endtask

    task automatic write_digits(input logic [DIGIT_BITS-1:0] digits);
        wait_until_quiet();
        cfg_write <= 1'b1;
        cfg_data  <= digits;
        @(posedge clk);
        cfg_write  <= 1'b0;
        digits_now = digits;
    endtask

    task automatic test_reset_digits();
        logic [RADICAND_BITS-1:0] values[6];
        values = '{0, 1, 2, 144, 2147395600, RADICAND_MAX};
        idle_percent = 0;
        foreach (values[i])
            send_radicand(values[i]);
    endtask

    task automatic test_directed();
        logic [RADICAND_BITS-1:0] values[5];
        values = '{0, 3, 99, 2147395599, 31'h2AAA_AAAA};
        for (int d = 0; d < 4; d++)
        begin
            write_digits(DIGIT_BITS'(d));
            foreach (values[i])
                send_radicand(values[i]);
        end
        send_radicand(31'h5555_5555);
        send_radicand(31'h4000_0000);
    endtask

    task automatic test_pause_and_resume();
        idle_percent = 0;
        repeat (10) send_radicand(pick_radicand());
        wait_until_quiet();
        repeat (10) send_radicand(pick_radicand());
    endtask

    task automatic test_random_phases();
        int idle_plan[6];
        int digit_plan[6];
        idle_plan  = '{0, 67, 22, 0, 67, 22};
        digit_plan = '{0, 3, 1, 2, 3, 0};
        foreach (idle_plan[p])
        begin
            write_digits(DIGIT_BITS'(digit_plan[p]));
            idle_percent = idle_plan[p];
            repeat (40) send_radicand(pick_radicand());
            write_digits(DIGIT_BITS'($urandom_range(0, 3)));
            repeat (45) send_radicand(pick_radicand());
        end
    endtask

    always @(posedge clk)
    begin
        root_result_t want;
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: root_scaled=%0d exact_square=%0b",
                             root_scaled, exact_square);
            end
            else
            begin
                want = pending_roots.pop_front();
                if (root_scaled !== want.root || exact_square !== want.exact)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: root_scaled exp %0d got %0d, exact_square exp %0b got %0b",
                                 want.root, root_scaled, want.exact, exact_square);
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired with %0d results outstanding", pending_roots.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        fail_count   = 0;
        idle_percent = 0;
        digits_now   = DIGITS_RESET;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        radicand  <= '0;
        cfg_write <= 1'b0;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_digits();
        test_directed();
        test_pause_and_resume();
        test_random_phases();

        wait_until_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_roots.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
